// ===== hdl/tels_pkg.sv =====
// ---------------------------------------------------------------------------
// tels_pkg
// Types, field widths, codes and the percent scaling helper shared by the
// timed event light scheduler and its divider.
// ---------------------------------------------------------------------------
package tels_pkg;

    localparam int PIN_W  = 3;
    localparam int TIME_W = 17;
    localparam int LVL_W  = 7;
    localparam int STEP_W = 8;
    localparam int DUR_W  = 11;
    localparam int DURS_W = 17;
    localparam int DUTY_W = 8;
    localparam int INC_W  = 9;
    localparam int PROD_W = INC_W + DURS_W;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic KIND_SWITCH = 1'b0;
    localparam logic KIND_RAMP   = 1'b1;

    // pin in the lowest bits, duration in the highest, as on the input stream
    typedef struct packed {
        logic [DUR_W-1:0]         dur_min;
        logic signed [STEP_W-1:0] step;
        logic [LVL_W-1:0]         level;
        logic [TIME_W-1:0]        start;
        logic                     kind;
        logic [PIN_W-1:0]         pin;
    } t_event;

    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic              kind;
        logic              sw;
        logic [DUTY_W-1:0] duty;
    } t_result;

    // x*255/100 truncated, x up to 128: reciprocal multiply, exact below 43690
    function automatic logic [INC_W-1:0] pct255(input logic [7:0] x);
        logic [15:0] v;
        logic [28:0] p;
        v = {x, 8'b0} - {8'b0, x};
        p = {13'b0, v} * 29'd5243;
        return p[27:19];
    endfunction

endpackage

// ===== hdl/tels_div.sv =====
// ---------------------------------------------------------------------------
// tels_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tels_div
    import tels_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DURS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_num;
    logic [DURS_W-1:0] r_rem;
    logic [DURS_W-1:0] r_div;
    logic [DURS_W:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[PROD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(PROD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                if (w_ge) begin
                    r_rem <= DURS_W'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[DURS_W-1:0];
                end
                r_num <= {r_num[PROD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== hdl/timed_event_light_scheduler.sv =====
// ---------------------------------------------------------------------------
// timed_event_light_scheduler
// Event table for timed light outputs: append, clear and per-tick apply.
// ---------------------------------------------------------------------------
// A tick scans the event memory once per output and decides whether the output
// needs an update: a switch result is emitted directly, a ramp is first
// calculated and, unless it is steady or past its end, divided before it is
// emitted. Emitting stalls while the pending slot cannot move to the output.
// Results leave through an output register and one pending slot.
// Reset empties the table, marks no output as applied and enables ticks.
// ---------------------------------------------------------------------------
module timed_event_light_scheduler
    import tels_pkg::*;
#(
    parameter int EVENT_CAPACITY = 32,
    parameter int OUTPUT_COUNT   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,    // schedule_enable
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // out_pin[2:0], event_kind[3], time_seconds[20:4], start_level[27:21],
    // step_percent[35:28], duration_minutes[46:36], zero [47]
    input  logic [47:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,        // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // drive_pin[2:0], switch_level[3], duty[11:4], zero [15:12]
    output logic [15:0] o_m_tdata,
    output logic        o_m_tuser,        // drive_kind
    output logic        o_m_tlast         // last_of_tick
);

    localparam int IW  = (EVENT_CAPACITY > 1) ? $clog2(EVENT_CAPACITY) : 1;
    localparam int CW  = $clog2(EVENT_CAPACITY + 1);
    localparam int PW  = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
    localparam int CMW = (PW > PIN_W) ? PW : PIN_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_PROD   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_FLUSH  = 3'd7;

    // event memory, read through a register
    t_event mem [EVENT_CAPACITY];

    logic [2:0]        r_state;
    logic              r_en;
    logic [CW-1:0]     r_cnt;
    logic [TIME_W-1:0] r_now;
    logic [PW-1:0]     r_pin;
    logic [CW-1:0]     r_addr;
    logic              r_rvld;
    logic [IW-1:0]     r_ridx;
    t_event            r_rdata;
    logic              r_seen;
    logic              r_found;
    logic [TIME_W-1:0] r_first_start;
    t_event            r_prev;
    logic [IW-1:0]     r_prev_idx;
    t_event            r_pair;
    logic [IW-1:0]     r_pair_idx;
    t_event            r_sel;
    logic              r_act_v [OUTPUT_COUNT];
    logic [IW-1:0]     r_act   [OUTPUT_COUNT];
    logic [DUTY_W-1:0] r_base;
    logic [INC_W-1:0]  r_inc;
    logic              r_incneg;
    logic signed [TIME_W:0] r_el;
    logic [DURS_W-1:0] r_durs;
    logic              r_neg;
    t_result           r_res;
    logic              r_pend_v;
    t_result           r_pend;
    logic              r_ov;
    t_result           r_out;
    logic              r_olast;

    t_event            w_in;
    logic [1:0]        w_mode;
    logic              w_acc;
    logic              w_wr;
    logic              w_rd;
    logic              w_match;
    logic              w_use_last;
    t_event            w_sel;
    logic [IW-1:0]     w_sel_idx;
    logic              w_have;
    logic              w_upd;
    logic              w_last_pin;
    logic              w_out_free;
    logic              w_ov_load;
    logic [INC_W-1:0]  w_base9;
    logic [7:0]        w_stepmag;
    logic [INC_W-1:0]  w_inc9;
    logic [TIME_W-1:0] w_elmag;
    logic [PROD_W-1:0] w_prod;
    logic [DUTY_W-1:0] w_inc8;
    logic              w_need_div;
    logic              w_div_start;
    logic              w_div_done;
    logic [PROD_W-1:0] w_quot;
    logic [DUTY_W-1:0] w_q8;

    assign w_mode = i_s_tuser;
    assign w_in   = i_s_tdata[46:0];
    assign w_acc  = i_s_tvalid && o_s_tready;
    assign w_wr   = w_acc && (w_mode == MODE_APPEND) && (r_cnt < CW'(EVENT_CAPACITY));
    assign w_rd   = (r_state == S_SCAN) && (r_addr < r_cnt);

    // hold the table: append at the fill count, read one entry per scan cycle
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_cnt[IW-1:0]] <= w_in;
        end
        if (w_rd) begin
            r_rdata <= mem[r_addr[IW-1:0]];
        end
    end

    assign w_match = r_rvld && (CMW'(r_rdata.pin) == CMW'(r_pin));

    // before the first or from the last event on, the last event applies
    assign w_use_last = (r_now < r_first_start) || (r_now >= r_prev.start);
    assign w_sel      = w_use_last ? r_prev : r_pair;
    assign w_sel_idx  = w_use_last ? r_prev_idx : r_pair_idx;
    assign w_have     = r_seen && (w_use_last || r_found);
    assign w_upd      = w_have && ((w_sel.dur_min != '0) || !r_act_v[r_pin] ||
                                   (r_act[r_pin] != w_sel_idx));
    assign w_last_pin = (r_pin == PW'(OUTPUT_COUNT - 1));
    assign w_out_free = !r_ov || i_m_tready;
    // move the pending result into the output register
    assign w_ov_load  = r_pend_v && w_out_free &&
                        ((r_state == S_EMIT) || (r_state == S_FLUSH));

    // ramp arithmetic: percent scaling, elapsed time, product for the divider
    assign w_base9    = pct255({1'b0, r_sel.level});
    assign w_stepmag  = r_sel.step[STEP_W-1] ? 8'(-r_sel.step) : 8'(r_sel.step);
    assign w_inc9     = pct255(w_stepmag);
    assign w_elmag    = r_el[TIME_W] ? TIME_W'(-r_el) : TIME_W'(r_el);
    assign w_prod     = {{DURS_W{1'b0}}, r_inc} * {{INC_W{1'b0}}, w_elmag};
    assign w_inc8     = r_incneg ? DUTY_W'(-r_inc[DUTY_W-1:0]) : r_inc[DUTY_W-1:0];
    assign w_need_div = (r_durs != '0) && !(r_el > $signed({1'b0, r_durs}));
    assign w_div_start = (r_state == S_PROD) && w_need_div;
    assign w_q8       = r_neg ? DUTY_W'(-w_quot[DUTY_W-1:0]) : w_quot[DUTY_W-1:0];

    tels_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_durs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 1'b1;
            r_cnt    <= '0;
            r_rvld   <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            for (int k = 0; k < OUTPUT_COUNT; k++) begin
                r_act_v[k] <= 1'b0;
            end
        end else begin
            if (w_ov_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            // a clear drops to manual mode
            if (w_acc && (w_mode == MODE_CLEAR)) begin
                r_en <= 1'b0;
            end else if (i_cfg_wr_en) begin
                r_en <= i_cfg_wr_data;
            end
            r_rvld <= w_rd;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_wr) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (w_mode == MODE_CLEAR) begin
                            r_cnt <= '0;
                        end
                        if ((w_mode == MODE_TICK) && r_en) begin
                            r_now   <= w_in.start;
                            r_pin   <= '0;
                            r_addr  <= '0;
                            r_seen  <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_rd) begin
                        r_addr <= r_addr + 1'b1;
                        r_ridx <= r_addr[IW-1:0];
                    end else if (!r_rvld) begin
                        r_state <= S_DECIDE;
                    end
                    // track first start, last event and the first bracketing pair
                    if (w_match) begin
                        if (!r_seen) begin
                            r_first_start <= r_rdata.start;
                            r_seen        <= 1'b1;
                        end else if (!r_found && (r_now >= r_prev.start) &&
                                     (r_now < r_rdata.start)) begin
                            r_found    <= 1'b1;
                            r_pair     <= r_prev;
                            r_pair_idx <= r_prev_idx;
                        end
                        r_prev     <= r_rdata;
                        r_prev_idx <= r_ridx;
                    end
                end
                S_DECIDE: begin
                    if (w_upd) begin
                        r_act_v[r_pin] <= 1'b1;
                        r_act[r_pin]   <= w_sel_idx;
                        r_sel          <= w_sel;
                        if (w_sel.kind == KIND_SWITCH) begin
                            r_res   <= '{pin: w_sel.pin, kind: KIND_SWITCH,
                                         sw: (w_sel.level != '0), duty: '0};
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end else if (w_last_pin) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_pin   <= r_pin + 1'b1;
                        r_addr  <= '0;
                        r_seen  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_CALC: begin
                    r_base   <= w_base9[DUTY_W-1:0];
                    r_inc    <= w_inc9;
                    r_incneg <= r_sel.step[STEP_W-1];
                    r_el     <= $signed({1'b0, r_now}) - $signed({1'b0, r_sel.start});
                    r_durs   <= {r_sel.dur_min, 6'b0} - {4'b0, r_sel.dur_min, 2'b0};
                    r_state  <= S_PROD;
                end
                S_PROD: begin
                    r_neg <= r_incneg ^ r_el[TIME_W];
                    // steady level keeps the base, past the end of the ramp adds the step
                    r_res <= '{pin: r_sel.pin, kind: KIND_RAMP, sw: 1'b0,
                               duty: (w_need_div || (r_durs == '0)) ? r_base
                                     : DUTY_W'(r_base + w_inc8)};
                    if (w_need_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res.duty <= DUTY_W'(r_base + w_q8);
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // park the result; the pending one leaves once the next is known
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_out   <= r_pend;
                            r_olast <= 1'b0;
                        end
                        r_pend   <= r_res;
                        r_pend_v <= 1'b1;
                        if (w_last_pin) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_pin   <= r_pin + 1'b1;
                            r_addr  <= '0;
                            r_seen  <= 1'b0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FLUSH: begin
                    // release the final result of the tick marked last
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out    <= r_pend;
                        r_olast  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'b0, r_out.duty, r_out.sw, r_out.pin};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_olast;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(EVENT_CAPACITY))
        else $error("event count beyond capacity");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("result left pending after tick");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

endmodule
